// ----- rtl/dlex_pkg.sv -----
// shared codes and result type for the declaration lexer
`timescale 1ns / 1ps
package dlex_pkg;

    // lexer states
    localparam logic [3:0] ST_START   = 4'd0;
    localparam logic [3:0] ST_KEYWORD = 4'd1;
    localparam logic [3:0] ST_WS1     = 4'd2;
    localparam logic [3:0] ST_IDENT   = 4'd3;
    localparam logic [3:0] ST_WS2     = 4'd4;
    localparam logic [3:0] ST_VALUE   = 4'd5;
    localparam logic [3:0] ST_STRING  = 4'd6;
    localparam logic [3:0] ST_SIGNED  = 4'd7;
    localparam logic [3:0] ST_NUM1    = 4'd8;
    localparam logic [3:0] ST_NUM2    = 4'd9;
    localparam logic [3:0] ST_HEX     = 4'd10;
    localparam logic [3:0] ST_EXP1    = 4'd11;
    localparam logic [3:0] ST_EXP2    = 4'd12;
    localparam logic [3:0] ST_SEMI    = 4'd13;
    localparam logic [3:0] ST_FINISH  = 4'd14;

    // character classes
    localparam logic [3:0] C_SPACE  = 4'd0;
    localparam logic [3:0] C_EXP    = 4'd1;
    localparam logic [3:0] C_HEXL   = 4'd2;
    localparam logic [3:0] C_LETTER = 4'd3;
    localparam logic [3:0] C_DIGIT  = 4'd4;
    localparam logic [3:0] C_UNDER  = 4'd5;
    localparam logic [3:0] C_EQUAL  = 4'd6;
    localparam logic [3:0] C_DOLLAR = 4'd7;
    localparam logic [3:0] C_APOS   = 4'd8;
    localparam logic [3:0] C_PM     = 4'd9;
    localparam logic [3:0] C_POINT  = 4'd10;
    localparam logic [3:0] C_SEMI   = 4'd11;
    localparam logic [3:0] C_OTHER  = 4'd12;

    // token actions
    localparam logic [2:0] A_SKIP   = 3'd0;
    localparam logic [2:0] A_APPEND = 3'd1;
    localparam logic [2:0] A_CLOSE  = 3'd2;
    localparam logic [2:0] A_EQUAL  = 3'd3;
    localparam logic [2:0] A_SEMI   = 3'd4;
    localparam logic [2:0] A_IGNORE = 3'd5;

    // token kinds
    localparam logic [3:0] K_NONE  = 4'd0;
    localparam logic [3:0] K_KEY   = 4'd1;
    localparam logic [3:0] K_IDENT = 4'd2;
    localparam logic [3:0] K_EQUAL = 4'd3;
    localparam logic [3:0] K_DEC   = 4'd4;
    localparam logic [3:0] K_HEX   = 4'd5;
    localparam logic [3:0] K_STR   = 4'd6;
    localparam logic [3:0] K_FLOAT = 4'd7;
    localparam logic [3:0] K_EXP   = 4'd8;
    localparam logic [3:0] K_SEMI  = 4'd9;

    typedef struct packed {
        logic [2:0] action;
        logic [3:0] token_kind;
        logic [7:0] out_symbol;
        logic       rejected;
        logic       finished;
        logic       end_of_sequence;
    } t_result;

endpackage

// ----- rtl/dlex_core.sv -----
// lexer state registers and next-state table for one character per cycle while enabled
`timescale 1ns / 1ps
module dlex_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic [7:0]         i_symbol,
    input  logic [3:0]         i_char_class,
    input  logic               i_first,
    input  logic               i_last,
    output dlex_pkg::t_result  o_result
);
    import dlex_pkg::*;

    logic [3:0] r_state;
    logic [3:0] r_kind;
    logic       r_reject;

    logic [3:0] n_state;
    logic [3:0] n_kind;
    logic       n_reject;

    logic [3:0] w_cls;
    logic       w_alpha;
    logic [3:0] w_st;
    logic [3:0] w_kind0;
    logic       w_rej0;
    logic       w_bad;
    logic [2:0] w_act;
    logic [3:0] w_ns;
    logic [3:0] w_nk;

    assign w_cls   = (i_char_class > C_OTHER) ? C_OTHER : i_char_class;
    assign w_alpha = (w_cls == C_EXP) || (w_cls == C_HEXL) || (w_cls == C_LETTER);

    // a first character restarts the sequence before it is lexed
    assign w_st    = i_first ? ST_START : r_state;
    assign w_kind0 = i_first ? K_NONE : r_kind;
    assign w_rej0  = i_first ? 1'b0 : r_reject;

    always_comb begin
        w_bad = 1'b0;
        w_act = A_SKIP;
        w_ns  = w_st;
        w_nk  = w_kind0;
        case (w_st)
            ST_START: begin
                if (w_cls == C_SPACE) w_act = A_SKIP;
                else if (w_alpha) begin
                    w_ns = ST_KEYWORD; w_nk = K_KEY; w_act = A_APPEND;
                end else w_bad = 1'b1;
            end
            ST_KEYWORD: begin
                if (w_alpha) begin
                    w_nk = K_KEY; w_act = A_APPEND;
                end else if (w_cls == C_SPACE) begin
                    w_ns = ST_WS1; w_nk = K_NONE; w_act = A_CLOSE;
                end else w_bad = 1'b1;
            end
            ST_WS1: begin
                if (w_alpha) begin
                    w_ns = ST_IDENT; w_nk = K_IDENT; w_act = A_APPEND;
                end else if (w_cls == C_SPACE) w_act = A_SKIP;
                else w_bad = 1'b1;
            end
            ST_IDENT: begin
                if (w_alpha || w_cls == C_DIGIT || w_cls == C_UNDER) begin
                    w_nk = K_IDENT; w_act = A_APPEND;
                end else if (w_cls == C_SPACE) begin
                    w_ns = ST_WS2; w_act = A_SKIP;
                end else if (w_cls == C_EQUAL) begin
                    w_ns = ST_VALUE; w_nk = K_NONE; w_act = A_EQUAL;
                end else w_bad = 1'b1;
            end
            ST_WS2: begin
                if (w_cls == C_SPACE) w_act = A_SKIP;
                else if (w_cls == C_EQUAL) begin
                    w_ns = ST_VALUE; w_nk = K_NONE; w_act = A_EQUAL;
                end else w_bad = 1'b1;
            end
            ST_VALUE: begin
                if (w_cls == C_DIGIT) begin
                    w_ns = ST_NUM1; w_nk = K_DEC; w_act = A_APPEND;
                end else if (w_cls == C_DOLLAR) begin
                    w_ns = ST_HEX; w_nk = K_HEX; w_act = A_APPEND;
                end else if (w_cls == C_APOS) begin
                    w_ns = ST_STRING; w_nk = K_STR; w_act = A_APPEND;
                end else if (w_cls == C_PM) begin
                    w_ns = ST_SIGNED; w_nk = K_DEC; w_act = A_APPEND;
                end else if (w_cls == C_SPACE) w_act = A_SKIP;
                else w_bad = 1'b1;
            end
            ST_STRING: begin
                // everything but the closing quote belongs to the string body
                if (w_cls == C_APOS) w_ns = ST_SEMI;
                else w_nk = K_STR;
                w_act = A_APPEND;
            end
            ST_SIGNED: begin
                if (w_cls == C_DIGIT) begin
                    w_ns = ST_NUM1; w_nk = K_DEC; w_act = A_APPEND;
                end else if (w_cls == C_DOLLAR) begin
                    w_ns = ST_HEX; w_nk = K_HEX; w_act = A_APPEND;
                end else w_bad = 1'b1;
            end
            ST_NUM1: begin
                if (w_cls == C_EXP) begin
                    w_ns = ST_EXP1; w_nk = K_EXP; w_act = A_APPEND;
                end else if (w_cls == C_DIGIT) begin
                    w_nk = K_DEC; w_act = A_APPEND;
                end else if (w_cls == C_POINT) begin
                    w_ns = ST_NUM2; w_nk = K_FLOAT; w_act = A_APPEND;
                end else if (w_cls == C_SEMI) begin
                    w_ns = ST_FINISH; w_nk = K_SEMI; w_act = A_SEMI;
                end else w_bad = 1'b1;
            end
            ST_NUM2: begin
                // fraction digits stay float
                if (w_cls == C_EXP) begin
                    w_ns = ST_EXP1; w_nk = K_EXP; w_act = A_APPEND;
                end else if (w_cls == C_DIGIT) begin
                    w_nk = K_FLOAT; w_act = A_APPEND;
                end else if (w_cls == C_SEMI) begin
                    w_ns = ST_FINISH; w_nk = K_SEMI; w_act = A_SEMI;
                end else w_bad = 1'b1;
            end
            ST_HEX: begin
                if (w_cls == C_EXP || w_cls == C_DIGIT || w_cls == C_HEXL) begin
                    w_nk = K_HEX; w_act = A_APPEND;
                end else if (w_cls == C_SEMI) begin
                    w_ns = ST_FINISH; w_nk = K_SEMI; w_act = A_SEMI;
                end else w_bad = 1'b1;
            end
            ST_EXP1: begin
                if (w_cls == C_DIGIT || w_cls == C_PM) begin
                    w_ns = ST_EXP2; w_nk = K_EXP; w_act = A_APPEND;
                end else if (w_cls == C_SEMI) begin
                    w_ns = ST_FINISH; w_nk = K_SEMI; w_act = A_SEMI;
                end else w_bad = 1'b1;
            end
            ST_EXP2: begin
                if (w_cls == C_DIGIT) begin
                    w_nk = K_EXP; w_act = A_APPEND;
                end else if (w_cls == C_SEMI) begin
                    w_ns = ST_FINISH; w_nk = K_SEMI; w_act = A_SEMI;
                end else w_bad = 1'b1;
            end
            ST_SEMI: begin
                if (w_cls == C_SPACE) w_act = A_SKIP;
                else if (w_cls == C_SEMI) begin
                    w_ns = ST_FINISH; w_nk = K_SEMI; w_act = A_SEMI;
                end else w_bad = 1'b1;
            end
            ST_FINISH: begin
                if (w_cls == C_SPACE) w_act = A_SKIP;
                else w_bad = 1'b1;
            end
            default: begin
                w_bad = 1'b1;
            end
        endcase
    end

    // a rejecting character leaves state and kind as they were
    always_comb begin
        if (w_rej0 || w_bad) begin
            n_state  = w_st;
            n_kind   = w_kind0;
            n_reject = 1'b1;
        end else begin
            n_state  = w_ns;
            n_kind   = w_nk;
            n_reject = 1'b0;
        end
    end

    always_comb begin
        o_result.action = (w_rej0 || w_bad) ? A_IGNORE : w_act;
        if (o_result.action == A_EQUAL) o_result.token_kind = K_EQUAL;
        else if (o_result.action == A_SEMI) o_result.token_kind = K_SEMI;
        else o_result.token_kind = n_kind;
        o_result.out_symbol      = i_symbol;
        o_result.rejected        = n_reject;
        o_result.finished        = (n_state == ST_FINISH);
        o_result.end_of_sequence = i_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_START;
            r_kind   <= K_NONE;
            r_reject <= 1'b0;
        end else if (i_en) begin
            r_state  <= n_state;
            r_kind   <= n_kind;
            r_reject <= n_reject;
        end
    end

endmodule

// ----- rtl/declaration_lexer_unit.sv -----
// top level of the declaration lexer: input register, lexer core, result register
//
//   channel   dir   tdata                          tuser                       tlast
//   s_axis    in    symbol[7:0]                    char_class[3:0], first[4]   last
//   m_axis    out   out_symbol[7:0], rejected[8],  action[2:0],                end_of_sequence
//                   finished[9], zero[15:10]       token_kind[6:3]
//
// one character per cycle sustained while m_axis_tready is high, through the input register then the result register
// the lexer state loop is a single combinational next-state table
// synchronous active-low reset empties both stages and puts the lexer at start
// a stalled m_axis holds the result register; the input register still fills
// once, then s_axis_tready drops until the result is taken
`timescale 1ns / 1ps
module declaration_lexer_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // symbol
    input  logic [4:0]  s_axis_tuser,   // char_class, first
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // out_symbol, rejected, finished, zero pad
    output logic [6:0]  m_axis_tuser,   // action, token_kind
    output logic        m_axis_tlast
);
    import dlex_pkg::*;

    logic       r_in_valid;
    logic [7:0] r_in_symbol;
    logic [3:0] r_in_class;
    logic       r_in_first;
    logic       r_in_last;

    logic    r_out_valid;
    t_result r_out;

    t_result w_result;
    logic    w_adv_out;
    logic    w_in_ready;
    logic    w_core_en;

    assign w_adv_out  = !r_out_valid || m_axis_tready;
    assign w_in_ready = !r_in_valid || w_adv_out;
    assign w_core_en  = r_in_valid && w_adv_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_ready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && w_in_ready) begin
            r_in_symbol <= s_axis_tdata;
            r_in_class  <= s_axis_tuser[3:0];
            r_in_first  <= s_axis_tuser[4];
            r_in_last   <= s_axis_tlast;
        end
    end

    dlex_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_en         (w_core_en),
        .i_symbol     (r_in_symbol),
        .i_char_class (r_in_class),
        .i_first      (r_in_first),
        .i_last       (r_in_last),
        .o_result     (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv_out) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_core_en) begin
            r_out <= w_result;
        end
    end

    assign s_axis_tready = w_in_ready;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {6'd0, r_out.finished, r_out.rejected, r_out.out_symbol};
    assign m_axis_tuser  = {r_out.token_kind, r_out.action};
    assign m_axis_tlast  = r_out.end_of_sequence;

`ifndef SYNTHESIS
    // ignored transactions go together with the sticky reject flag
    a_ignore_rej: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> ((r_out.action == A_IGNORE) == r_out.rejected))
        else $error("ignore action and reject flag disagree");

    a_semi_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.action == A_SEMI) |->
            (r_out.finished && r_out.token_kind == K_SEMI))
        else $error("semicolon emitted without finish");

    a_equal_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.action == A_EQUAL) |->
            (r_out.token_kind == K_EQUAL && !r_out.finished))
        else $error("equal token carries wrong kind");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !m_axis_tready) |=> (r_out_valid && $stable(r_out)))
        else $error("result changed while stalled");
`endif

endmodule
